>>> hw/rtl/ffa_pkg.sv
package ffa_pkg;

  localparam int WORD_W    = 16;
  localparam int WORD_BITS = 4;
  localparam int LEN_W     = 10;
  localparam int START_W   = 9;

  typedef enum logic [0:0] {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_LEN  = 2'd1,
    ST_NO_SPACE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_RD,
    S_WR,
    S_RESP
  } state_e;

  typedef struct packed {
    logic                 hit;
    logic [WORD_BITS-1:0] lane;
  } scan_hit_t;

endpackage

>>> hw/rtl/ffa_if.sv
interface ffa_req_if;
  logic                        valid;
  logic                        ready;
  ffa_pkg::cmd_e               command;
  logic [ffa_pkg::LEN_W-1:0]   run_length;
  logic [ffa_pkg::START_W-1:0] start_block;

  modport source (output valid, command, run_length, start_block, input ready);
  modport sink   (input valid, command, run_length, start_block, output ready);
endinterface

interface ffa_rsp_if;
  logic                        valid;
  logic                        ready;
  ffa_pkg::status_e            status;
  logic [ffa_pkg::START_W-1:0] granted_start;

  modport source (output valid, status, granted_start, input ready);
  modport sink   (input valid, status, granted_start, output ready);
endinterface

>>> hw/rtl/ffa_map_ram.sv
module ffa_map_ram #(
  parameter int DEPTH = 32,
  parameter int AW    = 5,
  parameter int W     = 16
) (
  input  logic         clk_i,
  input  logic         wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [W-1:0]  wr_data_i,
  input  logic         rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [W-1:0]  rd_data_o
);

  logic [W-1:0] mem_q [DEPTH];
  logic [W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> hw/rtl/ffa_word_scan.sv
module ffa_word_scan #(
  parameter int NUM_BLOCKS = 512,
  parameter int WaW        = 5,
  parameter int Rw         = 10
) (
  input  logic [ffa_pkg::WORD_W-1:0] word_i,
  input  logic [WaW-1:0]             addr_i,
  input  logic [Rw-1:0]              carry_i,
  input  logic [Rw-1:0]              len_i,
  output ffa_pkg::scan_hit_t         hit_o,
  output logic [Rw-1:0]              carry_o
);

  logic [ffa_pkg::WORD_W-1:0] used;
  logic [Rw-1:0]              run [ffa_pkg::WORD_W];
  logic [ffa_pkg::WORD_W-1:0] hitv;
  logic                       pf;
  logic [ffa_pkg::WORD_BITS-1:0] hu;

  always_comb begin
    for (int b = 0; b < ffa_pkg::WORD_W; b++) begin
      used[b] = word_i[b] |
                ({1'b0, addr_i, ffa_pkg::WORD_BITS'(b)} >= Rw'(NUM_BLOCKS));
    end
  end

  always_comb begin
    for (int j = 0; j < ffa_pkg::WORD_W; j++) begin
      pf = 1'b1;
      hu = '0;
      for (int b = 0; b < ffa_pkg::WORD_W; b++) begin
        if (b <= j && used[b]) begin
          pf = 1'b0;
          hu = ffa_pkg::WORD_BITS'(b);
        end
      end
      run[j]  = pf ? (carry_i + Rw'(j + 1)) : (Rw'(j) - Rw'(hu));
      hitv[j] = (run[j] >= len_i);
    end
  end

  always_comb begin
    hit_o.hit  = |hitv;
    hit_o.lane = '0;
    for (int j = ffa_pkg::WORD_W - 1; j >= 0; j--) begin
      if (hitv[j]) begin
        hit_o.lane = ffa_pkg::WORD_BITS'(j);
      end
    end
  end

  assign carry_o = run[ffa_pkg::WORD_W-1];

endmodule

>>> hw/rtl/first_fit_extent_allocator_unit.sv
// First-fit extent allocator over a free map of NUM_BLOCKS blocks.
// req_i (valid/ready) carries command, run_length and start_block; rsp_o
// (valid/ready) returns one transaction per request: status and granted_start.
// Allocate takes the lowest start whose whole run is free and marks it used;
// free clears a run, clipped at the end of the map.
// The map lives in a RAM of 16-bit words, one read and one write port.
// After reset a clearing pass writes zero to every map word, with req_i.ready
// low. Allocate: accept, scan one map word at a time up to the word where the
// run ends (or the last word if no run fits), then read and write back each
// marked word, then respond. Free: accept, read and write back each word
// touched, then respond.
// Bad lengths and empty frees go straight from accept to the response.
// The rate is set by the single RAM read port feeding the word scan
// unit, one word per cycle, and the read-modify-write of each marked word.
// One request is in flight at a time; a new request is accepted while the
// previous response still waits in the output register. If the receiver
// stalls, the next response waits in the sequencer until the register frees.
module first_fit_extent_allocator_unit #(
  parameter int NUM_BLOCKS = 512
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ffa_req_if.sink      req_i,
  ffa_rsp_if.source    rsp_o
);

  localparam int NumWords = (NUM_BLOCKS + ffa_pkg::WORD_W - 1) / ffa_pkg::WORD_W;
  localparam int WaW      = (NumWords > 1) ? $clog2(NumWords) : 1;
  localparam int Iw       = WaW + ffa_pkg::WORD_BITS;
  localparam int Rw       = Iw + 1;
  localparam int Sw       = (Rw > 11) ? Rw + 1 : 12;
  localparam logic [WaW-1:0] LastWord = WaW'(NumWords - 1);
  localparam logic [Sw-1:0]  NbS      = Sw'(NUM_BLOCKS);

  localparam int Wb = ffa_pkg::WORD_BITS;
  localparam int Ww = ffa_pkg::WORD_W;

  ffa_pkg::state_e  state_q, state_d;
  ffa_pkg::cmd_e    cmd_q, cmd_d;
  logic [Rw-1:0]    len_q, len_d;
  logic [WaW-1:0]   ex_q, ex_d;
  logic [Rw-1:0]    carry_q, carry_d;
  logic [Iw-1:0]    lo_q, lo_d;
  logic [Iw-1:0]    hi_q, hi_d;
  logic [WaW-1:0]   w_q, w_d;
  ffa_pkg::status_e st_q, st_d;
  logic [ffa_pkg::START_W-1:0] gs_q, gs_d;
  logic             out_valid_q, out_valid_d;
  ffa_pkg::status_e out_st_q, out_st_d;
  logic [ffa_pkg::START_W-1:0] out_gs_q, out_gs_d;

  logic             ram_we, ram_re;
  logic [WaW-1:0]   ram_wa, ram_ra;
  logic [Ww-1:0]    ram_wd, ram_rd;

  ffa_pkg::scan_hit_t scan_hit;
  logic [Rw-1:0]    scan_carry;

  logic             accept;
  logic             alloc_bad, free_none;
  logic [Sw-1:0]    fr_start_s, fr_end_s, fr_top_s;
  logic [Iw-1:0]    fr_lo, fr_hi;
  logic [Iw-1:0]    hit_end;
  logic [Rw-1:0]    hit_start_r;
  logic [Iw-1:0]    hit_start;
  logic [WaW-1:0]   lo_w, hi_w;
  logic [Ww-1:0]    lmask, umask, mask;
  logic             out_free;

  ffa_map_ram #(
    .DEPTH (NumWords),
    .AW    (WaW),
    .W     (Ww)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (ram_wa),
    .wr_data_i (ram_wd),
    .rd_en_i   (ram_re),
    .rd_addr_i (ram_ra),
    .rd_data_o (ram_rd)
  );

  ffa_word_scan #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .WaW        (WaW),
    .Rw         (Rw)
  ) u_scan (
    .word_i  (ram_rd),
    .addr_i  (ex_q),
    .carry_i (carry_q),
    .len_i   (len_q),
    .hit_o   (scan_hit),
    .carry_o (scan_carry)
  );

  assign req_i.ready = (state_q == ffa_pkg::S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;

  assign alloc_bad  = (req_i.run_length == '0) || (Sw'(req_i.run_length) > NbS);
  assign fr_start_s = Sw'(req_i.start_block);
  assign fr_end_s   = fr_start_s + Sw'(req_i.run_length);
  assign fr_top_s   = (fr_end_s > NbS) ? NbS : fr_end_s;
  assign free_none  = (fr_start_s >= NbS) || (req_i.run_length == '0);
  assign fr_lo      = Iw'(fr_start_s);
  assign fr_hi      = Iw'(fr_top_s - Sw'(1));

  assign hit_end     = {ex_q, scan_hit.lane};
  assign hit_start_r = {1'b0, hit_end} + Rw'(1) - len_q;
  assign hit_start   = Iw'(hit_start_r);

  assign lo_w  = lo_q[Iw-1:Wb];
  assign hi_w  = hi_q[Iw-1:Wb];
  assign lmask = (w_q == lo_w) ? ({Ww{1'b1}} << lo_q[Wb-1:0]) : {Ww{1'b1}};
  assign umask = (w_q == hi_w) ? ({Ww{1'b1}} >> (Wb'(Ww - 1) - hi_q[Wb-1:0]))
                               : {Ww{1'b1}};
  assign mask  = lmask & umask;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ffa_pkg::S_CLEAR: begin
        if (w_q == LastWord) state_d = ffa_pkg::S_IDLE;
      end
      ffa_pkg::S_IDLE: begin
        if (accept) begin
          if (req_i.command == ffa_pkg::CMD_ALLOC) begin
            state_d = alloc_bad ? ffa_pkg::S_RESP : ffa_pkg::S_SCAN;
          end else begin
            state_d = free_none ? ffa_pkg::S_RESP : ffa_pkg::S_RD;
          end
        end
      end
      ffa_pkg::S_SCAN: begin
        if (scan_hit.hit) begin
          state_d = ffa_pkg::S_RD;
        end else if (ex_q == LastWord) begin
          state_d = ffa_pkg::S_RESP;
        end
      end
      ffa_pkg::S_RD: state_d = ffa_pkg::S_WR;
      ffa_pkg::S_WR: begin
        state_d = (w_q == hi_w) ? ffa_pkg::S_RESP : ffa_pkg::S_RD;
      end
      ffa_pkg::S_RESP: begin
        if (out_free) state_d = ffa_pkg::S_IDLE;
      end
      default: state_d = ffa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_d       = cmd_q;
    len_d       = len_q;
    ex_d        = ex_q;
    carry_d     = carry_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    w_d         = w_q;
    st_d        = st_q;
    gs_d        = gs_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_st_d    = out_st_q;
    out_gs_d    = out_gs_q;
    ram_we      = 1'b0;
    ram_wa      = w_q;
    ram_wd      = '0;
    ram_re      = 1'b0;
    ram_ra      = w_q;
    unique case (state_q)
      ffa_pkg::S_CLEAR: begin
        ram_we = 1'b1;
        w_d    = (w_q == LastWord) ? '0 : w_q + WaW'(1);
      end
      ffa_pkg::S_IDLE: begin
        if (accept) begin
          cmd_d = req_i.command;
          st_d  = ffa_pkg::ST_OK;
          gs_d  = '0;
          if (req_i.command == ffa_pkg::CMD_ALLOC) begin
            if (alloc_bad) begin
              st_d = ffa_pkg::ST_BAD_LEN;
            end else begin
              len_d   = Rw'(req_i.run_length);
              ram_re  = 1'b1;
              ram_ra  = '0;
              ex_d    = '0;
              carry_d = '0;
            end
          end else if (!free_none) begin
            lo_d = fr_lo;
            hi_d = fr_hi;
            w_d  = fr_lo[Iw-1:Wb];
          end
        end
      end
      ffa_pkg::S_SCAN: begin
        if (scan_hit.hit) begin
          lo_d = hit_start;
          hi_d = hit_end;
          w_d  = hit_start[Iw-1:Wb];
          gs_d = ffa_pkg::START_W'(hit_start);
        end else if (ex_q != LastWord) begin
          ram_re  = 1'b1;
          ram_ra  = ex_q + WaW'(1);
          ex_d    = ex_q + WaW'(1);
          carry_d = scan_carry;
        end else begin
          st_d = ffa_pkg::ST_NO_SPACE;
        end
      end
      ffa_pkg::S_RD: begin
        ram_re = 1'b1;
      end
      ffa_pkg::S_WR: begin
        ram_we = 1'b1;
        ram_wd = (cmd_q == ffa_pkg::CMD_ALLOC) ? (ram_rd | mask) : (ram_rd & ~mask);
        w_d    = (w_q == LastWord) ? '0 : w_q + WaW'(1);
      end
      ffa_pkg::S_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_st_d    = st_q;
          out_gs_d    = gs_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ffa_pkg::S_CLEAR;
      w_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      w_q         <= w_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    len_q    <= len_d;
    ex_q     <= ex_d;
    carry_q  <= carry_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    st_q     <= st_d;
    gs_q     <= gs_d;
    out_st_q <= out_st_d;
    out_gs_q <= out_gs_d;
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = out_st_q;
  assign rsp_o.granted_start = out_gs_q;

endmodule

>>> hw/rtl/ffa_checker.sv
module ffa_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        req_valid_i,
  input logic                        req_ready_i,
  input logic                        rsp_valid_i,
  input logic                        rsp_ready_i,
  input ffa_pkg::status_e            rsp_status_i,
  input logic [ffa_pkg::START_W-1:0] rsp_start_i
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=>
      rsp_valid_i && $stable(rsp_status_i) && $stable(rsp_start_i))
    else $error("response changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i != ffa_pkg::ST_OK) |-> (rsp_start_i == '0))
    else $error("nonzero start on failed request");

  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !rsp_valid_i && !req_ready_i)
    else $error("activity at reset release");

endmodule

bind first_fit_extent_allocator_unit ffa_checker u_ffa_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status),
  .rsp_start_i  (rsp_o.granted_start)
);

>>> dv/testbench.sv
module testbench;

  localparam int BLOCKS      = 512;
  localparam int N_DIRECTED  = 23;
  localparam int N_RANDOM    = 1000;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN       = 64;

  typedef struct packed {
    ffa_pkg::status_e              status;
    logic [ffa_pkg::START_W-1:0]   granted_start;
  } extent_rsp_t;

  typedef struct packed {
    ffa_pkg::cmd_e                 cmd;
    logic [ffa_pkg::LEN_W-1:0]     run_length;
    logic [ffa_pkg::START_W-1:0]   start_block;
    logic                          typed;
    ffa_pkg::status_e              status;
    logic [ffa_pkg::START_W-1:0]   granted_start;
  } request_row_t;

  typedef struct {
    int unsigned first;
    int unsigned len;
  } extent_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ffa_req_if req_if ();
  ffa_rsp_if rsp_if ();

  first_fit_extent_allocator_unit #(
    .NUM_BLOCKS(BLOCKS)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always #10 clk_i = ~clk_i;

  request_row_t directed_rows [N_DIRECTED] = '{
    '{ffa_pkg::CMD_ALLOC, 10'd0,    9'd511, 1'b1, ffa_pkg::ST_BAD_LEN,  9'd0},
    '{ffa_pkg::CMD_ALLOC, 10'd513,  9'd0,   1'b1, ffa_pkg::ST_BAD_LEN,  9'd0},
    '{ffa_pkg::CMD_ALLOC, 10'd1023, 9'd511, 1'b1, ffa_pkg::ST_BAD_LEN,  9'd0},
    '{ffa_pkg::CMD_ALLOC, 10'd512,  9'd0,   1'b1, ffa_pkg::ST_OK,       9'd0},
    '{ffa_pkg::CMD_ALLOC, 10'd1,    9'd0,   1'b1, ffa_pkg::ST_NO_SPACE, 9'd0},
    '{ffa_pkg::CMD_FREE,  10'd0,    9'd0,   1'b1, ffa_pkg::ST_OK,       9'd0},
    '{ffa_pkg::CMD_ALLOC, 10'd1,    9'd0,   1'b1, ffa_pkg::ST_NO_SPACE, 9'd0},
    '{ffa_pkg::CMD_FREE,  10'd1023, 9'd511, 1'b1, ffa_pkg::ST_OK,       9'd0},
    '{ffa_pkg::CMD_ALLOC, 10'd1,    9'd0,   1'b1, ffa_pkg::ST_OK,       9'd511},
    '{ffa_pkg::CMD_FREE,  10'd50,   9'd100, 1'b1, ffa_pkg::ST_OK,       9'd0},
    '{ffa_pkg::CMD_ALLOC, 10'd51,   9'd0,   1'b1, ffa_pkg::ST_NO_SPACE, 9'd0},
    '{ffa_pkg::CMD_ALLOC, 10'd50,   9'd0,   1'b1, ffa_pkg::ST_OK,       9'd100},
    '{ffa_pkg::CMD_FREE,  10'd512,  9'd0,   1'b1, ffa_pkg::ST_OK,       9'd0},
    '{ffa_pkg::CMD_FREE,  10'd16,   9'd0,   1'b1, ffa_pkg::ST_OK,       9'd0},
    '{ffa_pkg::CMD_ALLOC, 10'd3,    9'd0,   1'b0, ffa_pkg::ST_OK,       9'd0},
    '{ffa_pkg::CMD_ALLOC, 10'd5,    9'd0,   1'b0, ffa_pkg::ST_OK,       9'd0},
    '{ffa_pkg::CMD_FREE,  10'd1,    9'd1,   1'b0, ffa_pkg::ST_OK,       9'd0},
    '{ffa_pkg::CMD_ALLOC, 10'd2,    9'd0,   1'b0, ffa_pkg::ST_OK,       9'd0},
    '{ffa_pkg::CMD_ALLOC, 10'd1,    9'd0,   1'b0, ffa_pkg::ST_OK,       9'd0},
    '{ffa_pkg::CMD_ALLOC, 10'd16,   9'd0,   1'b0, ffa_pkg::ST_OK,       9'd0},
    '{ffa_pkg::CMD_FREE,  10'd700,  9'd256, 1'b0, ffa_pkg::ST_OK,       9'd0},
    '{ffa_pkg::CMD_ALLOC, 10'd512,  9'd0,   1'b0, ffa_pkg::ST_OK,       9'd0},
    '{ffa_pkg::CMD_FREE,  10'd600,  9'd0,   1'b0, ffa_pkg::ST_OK,       9'd0}
  };

  logic [BLOCKS-1:0] used_blocks;
  extent_rsp_t       awaited_rsp_q [$];
  extent_t           live_extents [$];
  int unsigned       mismatches = 0;
  int unsigned       quiet_cycles = 0;
  bit                steady = 1'b0;

  function automatic extent_rsp_t serve_request(ffa_pkg::cmd_e cmd, int unsigned len,
                                                int unsigned first);
    extent_rsp_t rsp;
    int unsigned run;
    int unsigned last;
    extent_t     ext;
    rsp.status        = ffa_pkg::ST_OK;
    rsp.granted_start = '0;
    if (cmd == ffa_pkg::CMD_FREE) begin
      last = (first + len > BLOCKS) ? BLOCKS : first + len;
      for (int unsigned i = first; i < last; i++) used_blocks[i] = 1'b0;
      return rsp;
    end
    if (len == 0 || len > BLOCKS) begin
      rsp.status = ffa_pkg::ST_BAD_LEN;
      return rsp;
    end
    run = 0;
    for (int unsigned i = 0; i < BLOCKS; i++) begin
      if (used_blocks[i]) begin
        run = 0;
      end else begin
        run++;
        if (run == len) begin
          for (int unsigned j = i + 1 - len; j <= i; j++) used_blocks[j] = 1'b1;
          rsp.granted_start = ffa_pkg::START_W'(i + 1 - len);
          ext.first = i + 1 - len;
          ext.len   = len;
          live_extents.push_back(ext);
          return rsp;
        end
      end
    end
    rsp.status = ffa_pkg::ST_NO_SPACE;
    return rsp;
  endfunction

  task automatic issue_request(request_row_t row);
    extent_rsp_t rsp;
    if (!steady && $urandom_range(99) < 32) begin
      req_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 32);
    end
    req_if.valid       <= 1'b1;
    req_if.command     <= row.cmd;
    req_if.run_length  <= row.run_length;
    req_if.start_block <= row.start_block;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    rsp = serve_request(row.cmd, row.run_length, row.start_block);
    if (row.typed) begin
      rsp.status        = row.status;
      rsp.granted_start = row.granted_start;
    end
    awaited_rsp_q.push_back(rsp);
  endtask

  function automatic request_row_t random_request();
    request_row_t row;
    int unsigned  pick;
    int unsigned  idx;
    row.typed         = 1'b0;
    row.status        = ffa_pkg::ST_OK;
    row.granted_start = '0;
    row.start_block   = ffa_pkg::START_W'($urandom_range(BLOCKS - 1));
    row.cmd           = ffa_pkg::CMD_ALLOC;
    pick = $urandom_range(99);
    if (pick < 4) begin
      row.run_length = $urandom_range(1) ? '0 :
                       ffa_pkg::LEN_W'($urandom_range(1023, BLOCKS + 1));
    end else if (pick < 50 || (pick < 85 && live_extents.size() == 0)) begin
      pick = $urandom_range(99);
      if (pick < 80)      row.run_length = ffa_pkg::LEN_W'($urandom_range(16, 1));
      else if (pick < 95) row.run_length = ffa_pkg::LEN_W'($urandom_range(96, 17));
      else                row.run_length = ffa_pkg::LEN_W'($urandom_range(BLOCKS, 97));
    end else if (pick < 85) begin
      idx             = $urandom_range(live_extents.size() - 1);
      row.cmd         = ffa_pkg::CMD_FREE;
      row.start_block = ffa_pkg::START_W'(live_extents[idx].first);
      row.run_length  = ffa_pkg::LEN_W'(live_extents[idx].len);
      live_extents.delete(idx);
    end else begin
      row.cmd        = ffa_pkg::CMD_FREE;
      row.run_length = $urandom_range(1) ? ffa_pkg::LEN_W'($urandom_range(32)) :
                                           ffa_pkg::LEN_W'($urandom_range(1023));
    end
    return row;
  endfunction

  initial begin
    used_blocks = '0;
    req_if.valid       <= 1'b0;
    req_if.command     <= ffa_pkg::CMD_ALLOC;
    req_if.run_length  <= '0;
    req_if.start_block <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed_rows[i]) issue_request(directed_rows[i]);
    for (int i = 0; i < N_RANDOM; i++) begin
      steady = (i >= 300 && i < 450);
      issue_request(random_request());
    end
    steady = 1'b0;
    req_if.valid <= 1'b0;
    while (awaited_rsp_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (mismatches == 0 && awaited_rsp_q.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    extent_rsp_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (awaited_rsp_q.size() == 0) begin
        $error("unexpected transaction: status %0d, granted_start %0d",
               rsp_if.status, rsp_if.granted_start);
        mismatches++;
      end else begin
        want = awaited_rsp_q.pop_front();
        if (rsp_if.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, rsp_if.status);
          mismatches++;
        end
        if (rsp_if.granted_start !== want.granted_start) begin
          $error("granted_start: expected %0d, actual %0d",
                 want.granted_start, rsp_if.granted_start);
          mismatches++;
        end
      end
    end
    rsp_if.ready <= steady || ($urandom_range(99) >= 32);
  end

  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
